// ----- hw/rtl/smr_pkg.sv -----
// shared types, constants and the cordic arctangent table for the segment map raycaster
package smr_pkg;

    localparam int COORD_W      = 32;
    localparam int VEC_W        = 33;
    localparam int DIR_W        = 30;
    localparam int OPND_W       = 34;
    localparam int PROD_W       = 68;
    localparam int DEN_W        = 64;
    localparam int NUM_W        = 96;
    localparam int Q_W          = 32;
    localparam int DIST_W       = 31;
    localparam int TOL_W        = 32;
    localparam int DIR_BITS     = 28;
    localparam int CORDIC_STEPS = 30;
    localparam int CORD_W       = 33;
    localparam int ITER_W       = 5;
    localparam int DIV_CNT_W    = 6;

    localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 33'sd652032874;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_CAST = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_HEAD_GO,
        S_HEAD,
        S_RD,
        S_VEC,
        S_MUL,
        S_FOLD,
        S_TEST,
        S_DIV,
        S_NEXT,
        S_DONE
    } smr_state_t;

    typedef struct packed {
        logic start;
    } smr_unit_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } smr_unit_sts_t;

    // atan(2^-i) in 32-bit binary angle units
    function automatic logic [31:0] atan_entry(input logic [ITER_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000003;
            5'd29:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/smr_cordic.sv -----
// iterative cordic that turns a binary angle into a q28 unit heading
module smr_cordic #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  smr_pkg::smr_unit_ctl_t                 ctl,
    input  logic [ANGLE_BITS-1:0]                  angle,
    output smr_pkg::smr_unit_sts_t                 sts,
    output logic signed [smr_pkg::DIR_W-1:0]       dir_x,
    output logic signed [smr_pkg::DIR_W-1:0]       dir_y
);
    import smr_pkg::*;

    logic signed [CORD_W-1:0] x_reg, y_reg, z_reg;
    logic [ITER_W-1:0]        iter_reg;
    logic [1:0]               quad_reg;
    logic                     busy_reg, fold_reg, done_reg;
    logic signed [DIR_W-1:0]  dx_reg, dy_reg;

    logic [31:0]              a32, a_biased, res;
    logic [1:0]               quad_in;
    logic signed [CORD_W-1:0] xs, ys, at, x_step, y_step, z_step;
    logic signed [CORD_W-1:0] nx, ny;
    logic signed [CORD_W:0]   rx, ry;

    always_comb
    begin
        a32      = 32'(angle) << (32 - ANGLE_BITS);
        a_biased = a32 + 32'h20000000;
        quad_in  = a_biased[31:30];
        res      = a32 - {quad_in, 30'd0};
    end

    always_comb
    begin
        xs = x_reg >>> iter_reg;
        ys = y_reg >>> iter_reg;
        at = $signed({1'b0, atan_entry(iter_reg)});
        if (!z_reg[CORD_W-1])
        begin
            x_step = x_reg - ys;
            y_step = y_reg + xs;
            z_step = z_reg - at;
        end
        else
        begin
            x_step = x_reg + ys;
            y_step = y_reg - xs;
            z_step = z_reg + at;
        end
    end

    // quadrant unfold, then round half up to q28
    always_comb
    begin
        case (quad_reg)
            2'd0:    begin nx = x_reg;  ny = y_reg;  end
            2'd1:    begin nx = -y_reg; ny = x_reg;  end
            2'd2:    begin nx = -x_reg; ny = -y_reg; end
            default: begin nx = y_reg;  ny = -x_reg; end
        endcase
        rx = ($signed({nx[CORD_W-1], nx}) + (CORD_W+1)'(2)) >>> 2;
        ry = ($signed({ny[CORD_W-1], ny}) + (CORD_W+1)'(2)) >>> 2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fold_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && iter_reg == ITER_W'(CORDIC_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                fold_reg <= 1'b1;
            end
            else if (fold_reg)
            begin
                fold_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= $signed({res[31], res});
            quad_reg <= quad_in;
            iter_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg    <= x_step;
            y_reg    <= y_step;
            z_reg    <= z_step;
            iter_reg <= iter_reg + ITER_W'(1);
        end
        if (fold_reg)
        begin
            dx_reg <= rx[DIR_W-1:0];
            dy_reg <= ry[DIR_W-1:0];
        end
    end

    assign sts.busy = busy_reg | fold_reg;
    assign sts.done = done_reg;
    assign dir_x    = dx_reg;
    assign dir_y    = dy_reg;

endmodule

// ----- hw/rtl/smr_divider.sv -----
// restoring divider, one quotient bit per cycle, flags quotients of 2^32 and up
module smr_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  smr_pkg::smr_unit_ctl_t       ctl,
    input  logic [smr_pkg::NUM_W-1:0]    num,
    input  logic [smr_pkg::DEN_W-1:0]    den,
    output smr_pkg::smr_unit_sts_t       sts,
    output logic [smr_pkg::Q_W-1:0]      quot,
    output logic                         ovf
);
    import smr_pkg::*;

    logic [DEN_W-1:0]     rem_reg, den_reg;
    logic [Q_W-1:0]       q_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg, done_reg, ovf_reg;
    logic [DEN_W:0]       r2, diff;
    logic                 big;

    assign big  = num[NUM_W-1:Q_W] >= den;
    assign r2   = {rem_reg, q_reg[Q_W-1]};
    assign diff = r2 - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= !big;
                done_reg <= big;
            end
            else if (busy_reg && cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            ovf_reg <= big;
            den_reg <= den;
            rem_reg <= num[NUM_W-1:Q_W];
            q_reg   <= num[Q_W-1:0];
            cnt_reg <= DIV_CNT_W'(Q_W);
        end
        else if (busy_reg)
        begin
            if (!diff[DEN_W])
            begin
                rem_reg <= diff[DEN_W-1:0];
                q_reg   <= {q_reg[Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= r2[DEN_W-1:0];
                q_reg   <= {q_reg[Q_W-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quot     = q_reg;
    assign ovf      = ovf_reg;

endmodule

// ----- hw/rtl/segment_map_raycaster.sv -----
// top level: segment table, bounding box, shared multiplier and raycast sequencer
// add: the result is registered after the S_ADD and S_DONE states; raycast with zero range: after S_DONE alone
// raycast: the 30-step cordic, then for each stored segment six products on one shared multiplier
//   and, for a segment that passes the test, the 32-step divider
// one item at a time: in_stall is high from accept until the result is loaded
// reset clears control, count and box; table contents stay undefined until written
module segment_map_raycaster #(
    parameter int MAX_SEGMENTS = 32,
    parameter int ANGLE_BITS   = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  op,
    input  logic signed [smr_pkg::COORD_W-1:0]    seg_start_x,
    input  logic signed [smr_pkg::COORD_W-1:0]    seg_start_y,
    input  logic signed [smr_pkg::COORD_W-1:0]    seg_end_x,
    input  logic signed [smr_pkg::COORD_W-1:0]    seg_end_y,
    input  logic signed [smr_pkg::COORD_W-1:0]    ray_origin_x,
    input  logic signed [smr_pkg::COORD_W-1:0]    ray_origin_y,
    input  logic [ANGLE_BITS-1:0]                 ray_angle,
    input  logic [smr_pkg::DIST_W-1:0]            max_range,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  status,
    output logic                                  hit,
    output logic [smr_pkg::DIST_W-1:0]            hit_distance,
    output logic                                  bounds_valid,
    output logic signed [smr_pkg::COORD_W-1:0]    bound_min_x,
    output logic signed [smr_pkg::COORD_W-1:0]    bound_max_x,
    output logic signed [smr_pkg::COORD_W-1:0]    bound_min_y,
    output logic signed [smr_pkg::COORD_W-1:0]    bound_max_y,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [smr_pkg::TOL_W-1:0]             cfg_data
);
    import smr_pkg::*;

    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int ENT_W = 4 * COORD_W;

    smr_state_t state_reg, state_next;

    // segment table, one entry {start x, start y, end x, end y}
    logic [ENT_W-1:0] seg_mem [MAX_SEGMENTS];
    logic [ENT_W-1:0] rd_data_reg;

    logic [TOL_W-1:0]          tol_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          idx_reg;
    logic                      box_valid_reg;
    logic signed [COORD_W-1:0] box_min_x_reg, box_max_x_reg, box_min_y_reg, box_max_y_reg;

    // beat held from the input channel
    logic                      op_reg;
    logic signed [COORD_W-1:0] sx_reg, sy_reg, ex_reg, ey_reg, px_reg, py_reg;
    logic [ANGLE_BITS-1:0]     angle_reg;
    logic [DIST_W-1:0]         range_reg;

    // per segment datapath
    logic signed [VEC_W-1:0]   vx_reg, vy_reg, wx_reg, wy_reg;
    logic [2:0]                mstep_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [DEN_W-1:0]   den_reg, nu_reg;
    logic signed [PROD_W-1:0]  nt_reg;

    // running result
    logic                      status_reg, hit_reg;
    logic [DIST_W-1:0]         dist_reg;

    // output register
    logic                      out_valid_reg;
    logic                      o_status_reg, o_hit_reg, o_bvalid_reg;
    logic [DIST_W-1:0]         o_dist_reg;
    logic signed [COORD_W-1:0] o_min_x_reg, o_max_x_reg, o_min_y_reg, o_max_y_reg;

    smr_unit_ctl_t           cor_ctl, div_ctl;
    smr_unit_sts_t           cor_sts, div_sts;
    logic signed [DIR_W-1:0] dir_x, dir_y;
    logic [Q_W-1:0]          quot;
    logic                    ovf;

    logic in_take, out_free, full, seg_pass, seg_better;
    logic signed [OPND_W-1:0] opa, opb;
    logic signed [PROD_W-1:0] acc_hold, acc_diff;
    logic signed [COORD_W-1:0] lo_x, hi_x, lo_y, hi_y;
    logic [DEN_W-1:0]          tol_wide;
    logic [NUM_W-1:0]          div_num;

    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign full     = count_reg >= CNT_W'(MAX_SEGMENTS);

    smr_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cor_ctl),
        .angle (angle_reg),
        .sts   (cor_sts),
        .dir_x (dir_x),
        .dir_y (dir_y)
    );

    smr_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .num   (div_num),
        .den   (den_reg),
        .sts   (div_sts),
        .quot  (quot),
        .ovf   (ovf)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (op == OP_ADD)
                        state_next = S_ADD;
                    else if (max_range == '0)
                        state_next = S_DONE;
                    else
                        state_next = S_HEAD_GO;
                end
            end
            S_ADD:     state_next = S_DONE;
            S_HEAD_GO: state_next = S_HEAD;
            S_HEAD:
            begin
                if (cor_sts.done)
                    state_next = (count_reg == '0) ? S_DONE : S_RD;
            end
            S_RD:      state_next = S_VEC;
            S_VEC:     state_next = S_MUL;
            S_MUL:
            begin
                if (mstep_reg == 3'd6)
                    state_next = S_FOLD;
            end
            S_FOLD:    state_next = S_TEST;
            S_TEST:    state_next = seg_pass ? S_DIV : S_NEXT;
            S_DIV:
            begin
                if (div_sts.done)
                    state_next = S_NEXT;
            end
            S_NEXT:
            begin
                state_next = (idx_reg + CNT_W'(1) < count_reg) ? S_RD : S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall      = (state_reg != S_IDLE);
        cfg_ready     = 1'b1;
        cor_ctl.start = (state_reg == S_HEAD_GO);
        div_ctl.start = (state_reg == S_TEST) && seg_pass;
    end

    // box widened by both endpoints of the held segment
    always_comb
    begin
        lo_x = (sx_reg < ex_reg) ? sx_reg : ex_reg;
        hi_x = (sx_reg > ex_reg) ? sx_reg : ex_reg;
        lo_y = (sy_reg < ey_reg) ? sy_reg : ey_reg;
        hi_y = (sy_reg > ey_reg) ? sy_reg : ey_reg;
        if (box_valid_reg)
        begin
            if (box_min_x_reg < lo_x) lo_x = box_min_x_reg;
            if (box_max_x_reg > hi_x) hi_x = box_max_x_reg;
            if (box_min_y_reg < lo_y) lo_y = box_min_y_reg;
            if (box_max_y_reg > hi_y) hi_y = box_max_y_reg;
        end
    end

    // shared multiplier operand select
    // products: d.x*s.y, d.y*s.x, w.x*d.y, w.y*d.x, w.x*s.y, w.y*s.x
    always_comb
    begin
        case (mstep_reg)
            3'd0:    begin opa = OPND_W'(dir_x);  opb = OPND_W'(vy_reg); end
            3'd1:    begin opa = OPND_W'(dir_y);  opb = OPND_W'(vx_reg); end
            3'd2:    begin opa = OPND_W'(wx_reg); opb = OPND_W'(dir_y);  end
            3'd3:    begin opa = OPND_W'(wy_reg); opb = OPND_W'(dir_x);  end
            3'd4:    begin opa = OPND_W'(wx_reg); opb = OPND_W'(vy_reg); end
            default: begin opa = OPND_W'(wy_reg); opb = OPND_W'(vx_reg); end
        endcase
        case (mstep_reg)
            3'd2:    acc_hold = PROD_W'(den_reg);
            3'd4:    acc_hold = PROD_W'(nu_reg);
            default: acc_hold = nt_reg;
        endcase
        acc_diff = acc_hold - prod_reg;
    end

    // after folding the sign: den above tolerance, t >= 0, 0 <= u <= den
    always_comb
    begin
        tol_wide   = DEN_W'(tol_reg) << DIR_BITS;
        seg_pass   = ($unsigned(den_reg) > tol_wide) && !nt_reg[PROD_W-1]
                     && !nu_reg[DEN_W-1] && (nu_reg <= den_reg);
        div_num    = {nt_reg[NUM_W-DIR_BITS-1:0], {DIR_BITS{1'b0}}};
        seg_better = !ovf && (quot <= {1'b0, range_reg})
                     && (!hit_reg || quot[DIST_W-1:0] < dist_reg);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tol_reg       <= '0;
            count_reg     <= '0;
            box_valid_reg <= 1'b0;
            box_min_x_reg <= '0;
            box_max_x_reg <= '0;
            box_min_y_reg <= '0;
            box_max_y_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                tol_reg <= cfg_data;
            if (state_reg == S_ADD && !full)
            begin
                count_reg     <= count_reg + CNT_W'(1);
                box_valid_reg <= 1'b1;
                box_min_x_reg <= lo_x;
                box_max_x_reg <= hi_x;
                box_min_y_reg <= lo_y;
                box_max_y_reg <= hi_y;
            end
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // table write at the fill point, registered read at the walk index
    always_ff @(posedge clk)
    begin
        if (state_reg == S_ADD && !full)
            seg_mem[count_reg[IDX_W-1:0]] <= {sx_reg, sy_reg, ex_reg, ey_reg};
        rd_data_reg <= seg_mem[idx_reg[IDX_W-1:0]];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg     <= op;
            sx_reg     <= seg_start_x;
            sy_reg     <= seg_start_y;
            ex_reg     <= seg_end_x;
            ey_reg     <= seg_end_y;
            px_reg     <= ray_origin_x;
            py_reg     <= ray_origin_y;
            angle_reg  <= ray_angle;
            range_reg  <= max_range;
            status_reg <= STATUS_OK;
            hit_reg    <= 1'b0;
            dist_reg   <= '0;
            idx_reg    <= '0;
        end

        if (state_reg == S_ADD)
            status_reg <= full ? STATUS_FULL : STATUS_OK;

        if (state_reg == S_VEC)
        begin
            vx_reg    <= VEC_W'($signed(rd_data_reg[2*COORD_W-1:COORD_W]))
                         - VEC_W'($signed(rd_data_reg[4*COORD_W-1:3*COORD_W]));
            vy_reg    <= VEC_W'($signed(rd_data_reg[COORD_W-1:0]))
                         - VEC_W'($signed(rd_data_reg[3*COORD_W-1:2*COORD_W]));
            wx_reg    <= VEC_W'($signed(rd_data_reg[4*COORD_W-1:3*COORD_W]))
                         - VEC_W'(px_reg);
            wy_reg    <= VEC_W'($signed(rd_data_reg[3*COORD_W-1:2*COORD_W]))
                         - VEC_W'(py_reg);
            mstep_reg <= '0;
        end

        if (state_reg == S_MUL)
        begin
            mstep_reg <= mstep_reg + 3'd1;
            if (mstep_reg != 3'd6)
                prod_reg <= opa * opb;
            case (mstep_reg)
                3'd1:    den_reg <= prod_reg[DEN_W-1:0];
                3'd2:    den_reg <= acc_diff[DEN_W-1:0];
                3'd3:    nu_reg  <= prod_reg[DEN_W-1:0];
                3'd4:    nu_reg  <= acc_diff[DEN_W-1:0];
                3'd5:    nt_reg  <= prod_reg;
                3'd6:    nt_reg  <= acc_diff;
                default: ;
            endcase
        end

        // make the denominator positive, carry the sign into both numerators
        if (state_reg == S_FOLD && den_reg[DEN_W-1])
        begin
            den_reg <= -den_reg;
            nu_reg  <= -nu_reg;
            nt_reg  <= -nt_reg;
        end

        // strict compare keeps the earlier segment on equal distances
        if (state_reg == S_DIV && div_sts.done && seg_better)
        begin
            hit_reg  <= 1'b1;
            dist_reg <= quot[DIST_W-1:0];
        end

        if (state_reg == S_NEXT)
            idx_reg <= idx_reg + CNT_W'(1);

        if (state_reg == S_DONE && out_free)
        begin
            o_status_reg <= (op_reg == OP_ADD) ? status_reg : STATUS_OK;
            o_hit_reg    <= hit_reg;
            o_dist_reg   <= dist_reg;
            o_bvalid_reg <= box_valid_reg;
            o_min_x_reg  <= box_min_x_reg;
            o_max_x_reg  <= box_max_x_reg;
            o_min_y_reg  <= box_min_y_reg;
            o_max_y_reg  <= box_max_y_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = o_status_reg;
    assign hit          = o_hit_reg;
    assign hit_distance = o_dist_reg;
    assign bounds_valid = o_bvalid_reg;
    assign bound_min_x  = o_min_x_reg;
    assign bound_max_x  = o_max_x_reg;
    assign bound_min_y  = o_min_y_reg;
    assign bound_max_y  = o_max_y_reg;

endmodule

// ----- hw/rtl/smr_checker.sv -----
// port level checks for the segment map raycaster, bound to the top level
module smr_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_stall,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic                                  status,
    input logic                                  hit,
    input logic [smr_pkg::DIST_W-1:0]            hit_distance,
    input logic                                  bounds_valid,
    input logic signed [smr_pkg::COORD_W-1:0]    bound_min_x,
    input logic signed [smr_pkg::COORD_W-1:0]    bound_max_x,
    input logic signed [smr_pkg::COORD_W-1:0]    bound_min_y,
    input logic signed [smr_pkg::COORD_W-1:0]    bound_max_y
);
    import smr_pkg::*;

    // one item in flight: the beat after an accept is stalled
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted again right after an accept");

    // a result is either a full add or a raycast, never both flags
    a_status_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(status && hit))
        else $error("status and hit both set");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> hit_distance == '0)
        else $error("distance nonzero without a hit");

    a_empty_box: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bounds_valid |-> bound_min_x == '0 && bound_max_x == '0
                                       && bound_min_y == '0 && bound_max_y == '0)
        else $error("bounds nonzero while empty");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit_distance) && $stable(hit))
        else $error("stalled result changed");

endmodule

bind segment_map_raycaster smr_checker u_smr_checker (.*);

// ----- verif/segment_map_raycaster_checker.sv -----
`timescale 1ns / 100ps
// checker for the segment map raycaster: channel monitor, predictor and result compare
module segment_map_raycaster_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        op,
    input  logic [31:0] seg_start_x,
    input  logic [31:0] seg_start_y,
    input  logic [31:0] seg_end_x,
    input  logic [31:0] seg_end_y,
    input  logic [31:0] ray_origin_x,
    input  logic [31:0] ray_origin_y,
    input  logic [15:0] ray_angle,
    input  logic [30:0] max_range,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        status,
    input  logic        hit,
    input  logic [30:0] hit_distance,
    input  logic        bounds_valid,
    input  logic [31:0] bound_min_x,
    input  logic [31:0] bound_max_x,
    input  logic [31:0] bound_min_y,
    input  logic [31:0] bound_max_y,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output int          mismatch_count,
    output int          results_owed,
    output int          hits_seen,
    output int          full_rejects
);
    import smr_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic        status;
        logic        hit;
        logic [30:0] hit_dist;
        logic        box_ok;
        logic [31:0] min_x;
        logic [31:0] max_x;
        logic [31:0] min_y;
        logic [31:0] max_y;
    } ray_result_t;

    ray_result_t result_q[$];

    // predicted block state
    logic [31:0] tolerance;
    longint      wall_ax[32], wall_ay[32], wall_bx[32], wall_by[32];
    int          wall_count;
    logic        box_ok;
    logic [31:0] box_lo_x, box_hi_x, box_lo_y, box_hi_y;

    // unit heading in Q28 from a binary angle
    function automatic void unit_heading(input logic [15:0] ang,
                                         output longint dx, output longint dy);
        logic [31:0] a32, res;
        logic [1:0]  quad;
        longint      x, y, z, xs, ys, nx, ny;
        a32  = {ang, 16'h0000};
        quad = 2'((a32 + 32'h2000_0000) >> 30);
        res  = a32 - {quad, 30'b0};
        z    = longint'(signed'(res));
        x    = longint'(CORDIC_GAIN);
        y    = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys; y = y + xs; z = z - longint'(atan_entry(5'(i)));
            end
            else
            begin
                x = x + ys; y = y - xs; z = z + longint'(atan_entry(5'(i)));
            end
        end
        case (quad)
            2'd0:    begin nx = x;  ny = y;  end
            2'd1:    begin nx = -y; ny = x;  end
            2'd2:    begin nx = -x; ny = -y; end
            default: begin nx = y;  ny = -x; end
        endcase
        dx = (nx + 2) >>> 2;
        dy = (ny + 2) >>> 2;
    endfunction

    // nearest hit over the stored walls
    function automatic void nearest_wall(output logic found, output logic [30:0] near_dist);
        longint      px, py, dx, dy, sx, sy, wx, wy, den, nu, mag;
        logic [63:0] tol_w;
        wide_t       nt, q, best;
        found = 1'b0;
        best  = '0;
        if (max_range != '0)
        begin
            px    = longint'(signed'(ray_origin_x));
            py    = longint'(signed'(ray_origin_y));
            tol_w = {32'b0, tolerance} << DIR_BITS;
            unit_heading(ray_angle, dx, dy);
            for (int k = 0; k < wall_count; k++)
            begin
                sx  = wall_bx[k] - wall_ax[k];
                sy  = wall_by[k] - wall_ay[k];
                wx  = wall_ax[k] - px;
                wy  = wall_ay[k] - py;
                den = dx * sy - dy * sx;
                nu  = wx * dy - wy * dx;
                nt  = wide_t'(wx) * wide_t'(sy) - wide_t'(wy) * wide_t'(sx);
                mag = den < 0 ? -den : den;
                if (64'(mag) <= tol_w)
                    continue;
                if (den < 0)
                begin
                    den = -den; nu = -nu; nt = -nt;
                end
                if (nt < 0 || nu < 0 || nu > den)
                    continue;
                q = (nt <<< DIR_BITS) / wide_t'(den);
                if (q <= wide_t'(max_range) && (!found || q < best))
                begin
                    found = 1'b1;
                    best  = q;
                end
            end
        end
        near_dist = 31'(best);
    endfunction

    function automatic void widen_box(input logic [31:0] x, input logic [31:0] y);
        if (!box_ok)
        begin
            box_ok   = 1'b1;
            box_lo_x = x; box_hi_x = x;
            box_lo_y = y; box_hi_y = y;
        end
        else
        begin
            if (signed'(x) < signed'(box_lo_x)) box_lo_x = x;
            if (signed'(x) > signed'(box_hi_x)) box_hi_x = x;
            if (signed'(y) < signed'(box_lo_y)) box_lo_y = y;
            if (signed'(y) > signed'(box_hi_y)) box_hi_y = y;
        end
    endfunction

    always @(posedge clk)
    begin
        ray_result_t want, got;
        logic        found;
        logic [30:0] near_dist;
        if (!rst_n)
        begin
            tolerance      = '0;
            wall_count     = 0;
            box_ok         = 1'b0;
            box_lo_x       = '0; box_hi_x = '0; box_lo_y = '0; box_hi_y = '0;
            mismatch_count = 0;
            results_owed   = 0;
            hits_seen      = 0;
            full_rejects   = 0;
            result_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                tolerance = cfg_data;

            // result beat against the oldest prediction
            if (out_valid && !out_stall)
            begin
                got = '{status, hit, hit_distance, bounds_valid,
                        bound_min_x, bound_max_x, bound_min_y, bound_max_y};
                if (result_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result beat with nothing predicted: %p", $realtime, got);
                end
                else
                begin
                    want = result_q.pop_front();
                    results_owed--;
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: result differs\n  expected %p\n  actual   %p",
                                     $realtime, want, got);
                    end
                    if (got.hit) hits_seen++;
                    if (got.status) full_rejects++;
                end
            end

            // input beat: update the predicted state and queue the result
            if (in_valid && !in_stall)
            begin
                want = '0;
                if (op == OP_ADD)
                begin
                    if (wall_count >= 32)
                        want.status = STATUS_FULL;
                    else
                    begin
                        wall_ax[wall_count] = longint'(signed'(seg_start_x));
                        wall_ay[wall_count] = longint'(signed'(seg_start_y));
                        wall_bx[wall_count] = longint'(signed'(seg_end_x));
                        wall_by[wall_count] = longint'(signed'(seg_end_y));
                        wall_count++;
                        widen_box(seg_start_x, seg_start_y);
                        widen_box(seg_end_x, seg_end_y);
                    end
                end
                else
                begin
                    nearest_wall(found, near_dist);
                    want.hit      = found;
                    want.hit_dist = near_dist;
                end
                want.box_ok = box_ok;
                want.min_x  = box_lo_x; want.max_x = box_hi_x;
                want.min_y  = box_lo_y; want.max_y = box_hi_y;
                result_q = {result_q, want};
                results_owed++;
            end
        end
    end
endmodule

// ----- verif/segment_map_raycaster_tb.sv -----
`timescale 1ns / 100ps
// testbench top for the segment map raycaster: clock, reset, stimulus and verdict
module segment_map_raycaster_tb;
    import smr_pkg::*;

    localparam int  IDLE_LIMIT = 20000;  // a full-table cast plus the long hold fits easily
    localparam logic [31:0] TEN = 32'd655360;  // 10 inches in Q16.16

    logic        clk;
    logic        rst_n;
    logic        in_valid, in_stall;
    logic        op;
    logic [31:0] seg_start_x, seg_start_y, seg_end_x, seg_end_y;
    logic [31:0] ray_origin_x, ray_origin_y;
    logic [15:0] ray_angle;
    logic [30:0] max_range;
    logic        out_valid, out_stall;
    logic        status, hit, bounds_valid;
    logic [30:0] hit_distance;
    logic [31:0] bound_min_x, bound_max_x, bound_min_y, bound_max_y;
    logic        cfg_valid, cfg_ready;
    logic [31:0] cfg_data;

    int mismatch_count, results_owed, hits_seen, full_rejects;
    int items_sent, casts_sent, idle_cycles;

    // burst mode: neither side idles
    logic burst;
    // long receiver hold requested by the stimulus, served once by the sink
    logic hold_req, hold_done;

    segment_map_raycaster uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op),
        .seg_start_x(seg_start_x), .seg_start_y(seg_start_y),
        .seg_end_x(seg_end_x), .seg_end_y(seg_end_y),
        .ray_origin_x(ray_origin_x), .ray_origin_y(ray_origin_y),
        .ray_angle(ray_angle), .max_range(max_range),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .hit(hit), .hit_distance(hit_distance),
        .bounds_valid(bounds_valid),
        .bound_min_x(bound_min_x), .bound_max_x(bound_max_x),
        .bound_min_y(bound_min_y), .bound_max_y(bound_max_y),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    segment_map_raycaster_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .op(op),
        .seg_start_x(seg_start_x), .seg_start_y(seg_start_y),
        .seg_end_x(seg_end_x), .seg_end_y(seg_end_y),
        .ray_origin_x(ray_origin_x), .ray_origin_y(ray_origin_y),
        .ray_angle(ray_angle), .max_range(max_range),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .hit(hit), .hit_distance(hit_distance),
        .bounds_valid(bounds_valid),
        .bound_min_x(bound_min_x), .bound_max_x(bound_max_x),
        .bound_min_y(bound_min_y), .bound_max_y(bound_max_y),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .mismatch_count(mismatch_count), .results_owed(results_owed),
        .hits_seen(hits_seen), .full_rejects(full_rejects)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // coordinates: mostly a few tens of inches so rays actually meet walls,
    // sometimes full-width or pinned to the signed extremes
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
        endcase
    endfunction

    function automatic logic [30:0] pick_range();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 31'h7FFF_FFFF;
            2:       return 31'($urandom);
            default: return 31'($urandom_range(32'h0000_1000, 32'h0300_0000));
        endcase
    endfunction

    // one input beat, with a random gap ahead of it unless bursting
    task automatic send_item(input logic o, input logic [31:0] sx, input logic [31:0] sy,
                             input logic [31:0] ex, input logic [31:0] ey,
                             input logic [31:0] ox, input logic [31:0] oy,
                             input logic [15:0] ang, input logic [30:0] rng);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= o;
        seg_start_x  <= sx; seg_start_y <= sy;
        seg_end_x    <= ex; seg_end_y   <= ey;
        ray_origin_x <= ox; ray_origin_y <= oy;
        ray_angle    <= ang;
        max_range    <= rng;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (o == OP_CAST) casts_sent++;
    endtask

    task automatic add_wall(input logic [31:0] sx, input logic [31:0] sy,
                            input logic [31:0] ex, input logic [31:0] ey);
        send_item(OP_ADD, sx, sy, ex, ey, $urandom, $urandom, 16'($urandom), 31'($urandom));
    endtask

    task automatic cast_ray(input logic [31:0] ox, input logic [31:0] oy,
                            input logic [15:0] ang, input logic [30:0] rng);
        send_item(OP_CAST, $urandom, $urandom, $urandom, $urandom, ox, oy, ang, rng);
    endtask

    // drain the block, then write the tolerance register
    task automatic drain_and_set(input logic [31:0] tol);
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= tol;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int count, input int burst_from, input int burst_to);
        for (int n = 0; n < count; n++)
        begin
            burst = (n >= burst_from && n < burst_to);
            if ($urandom_range(0, 9) < 3)
                add_wall(pick_coord(), pick_coord(), pick_coord(), pick_coord());
            else
                cast_ray(pick_coord(), pick_coord(), 16'($urandom), pick_range());
        end
        burst = 1'b0;
    endtask

    // result side: random stalls per beat, plus one long hold on request
    initial
    begin
        int wait_n;
        out_stall = 1'b1;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req && !hold_done)
                wait_n = 300;
            else
                wait_n = burst ? 0 : $urandom_range(0, 17);
            if (wait_n > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_n) @(posedge clk);
                if (wait_n == 300) hold_done <= 1'b1;
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // watchdog: too long without any beat on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog expired, %0d results still owed", results_owed);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        op           = OP_ADD;
        seg_start_x  = '0; seg_start_y  = '0; seg_end_x = '0; seg_end_y = '0;
        ray_origin_x = '0; ray_origin_y = '0;
        ray_angle    = '0;
        max_range    = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        burst        = 1'b0;
        hold_req     = 1'b0;
        items_sent   = 0;
        casts_sent   = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, a box of walls around the origin, ties and extremes
        drain_and_set(32'h0);
        cast_ray(0, 0, 16'd0, 31'h7FFF_FFFF);           // nothing stored yet
        add_wall(TEN, -TEN, TEN, TEN);                  // right wall
        add_wall(-TEN, TEN, TEN, TEN);                  // top wall
        add_wall(-TEN, -TEN, -TEN, TEN);                // left wall
        add_wall(TEN, -TEN, -TEN, -TEN);                // bottom wall
        add_wall(TEN, TEN, TEN, -TEN);                  // right wall again, reversed: tie
        cast_ray(0, 0, 16'd0, 31'h7FFF_FFFF);
        cast_ray(0, 0, 16'd16384, 31'h7FFF_FFFF);
        cast_ray(0, 0, 16'd32768, 31'h7FFF_FFFF);
        cast_ray(0, 0, 16'd49152, 31'h7FFF_FFFF);
        cast_ray(0, 0, 16'd8192, 31'h7FFF_FFFF);        // straight into a corner
        cast_ray(0, 0, 16'd0, 31'h0);                   // zero range
        cast_ray(0, 0, 16'd0, 31'(TEN >> 1));            // wall out of range
        cast_ray(0, 0, 16'd0, 31'(TEN));                 // range right at the wall
        cast_ray(0, 0, 16'hFFFF, 31'h0000_0001);
        add_wall(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        add_wall(0, 0, 0, 0);                           // degenerate, always parallel
        cast_ray(32'h8000_0000, 32'h8000_0000, 16'd8192, 31'h7FFF_FFFF);
        cast_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 31'h7FFF_FFFF);
        cast_ray(TEN, 0, 16'd16384, 31'h7FFF_FFFF);     // runs along the right wall
        drain_and_set(32'hFFFF_FFFF);                   // every wall counts as parallel
        cast_ray(0, 0, 16'd0, 31'h7FFF_FFFF);
        cast_ray(0, 0, 16'd16384, 31'h7FFF_FFFF);

        // random phases under several tolerances
        drain_and_set(32'h0);
        random_phase(100, 20, 45);
        drain_and_set($urandom_range(0, 32'h0010_0000));
        hold_req <= 1'b1;                               // sink holds off while we keep sending
        random_phase(100, 0, 0);
        drain_and_set(32'hFFFF_FFFF);
        random_phase(40, 0, 0);
        drain_and_set($urandom);
        random_phase(80, 60, 80);
        drain_and_set(32'h0000_0001);
        random_phase(60, 0, 0);

        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
        repeat (50) @(posedge clk);

        $display("sent %0d beats (%0d raycasts), %0d hits, %0d adds refused on a full table",
                 items_sent, casts_sent, hits_seen, full_rejects);
        $display("tolerance swept over zero, one, small, random and all-ones settings");
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
